### rtl/lcsb_pkg.sv
// Package: state and error codes, result word type and backoff table for the link supervisor.
`timescale 1ns / 1ps

package lcsb_pkg;

	localparam int unsigned BACKOFF_STEPS = 7;

	localparam logic [1:0] MODE_POLL    = 2'd0;
	localparam logic [1:0] MODE_CONNECT = 2'd1;
	localparam logic [1:0] MODE_STOP    = 2'd2;

	localparam logic [1:0] LS_CONNECTED = 2'd0;
	localparam logic [1:0] LS_FAIL      = 2'd1;
	localparam logic [1:0] LS_NO_NET    = 2'd2;

	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_CONNECTING = 3'd1;
	localparam logic [2:0] ST_CONNECTED  = 3'd2;
	localparam logic [2:0] ST_RETRY      = 3'd3;
	localparam logic [2:0] ST_FAILED     = 3'd4;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_LOST    = 3'd1;
	localparam logic [2:0] ERR_CONNECT = 3'd2;
	localparam logic [2:0] ERR_TIMEOUT = 3'd3;
	localparam logic [2:0] ERR_REFUSED = 3'd4;

	localparam logic REG_TIMEOUT      = 1'b0;
	localparam logic REG_MAX_ATTEMPTS = 1'b1;

	localparam logic [8:0] JITTER_WRAP = 9'd501;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] now_ms;
		logic [1:0]  link_status;
		logic        addr_assigned;
		logic        begin_failed;
		logic [8:0]  jitter_ms;
		logic        finite_mode;
	} item_t;

	typedef struct packed {
		logic [2:0]  link_state;
		logic [7:0]  attempt_count;
		logic [2:0]  error_code;
		logic        start_request;
		logic        drop_request;
		logic [15:0] retry_delay_ms;
		logic        is_up;
	} result_t;

	function automatic logic [15:0] backoff_base(input logic [3:0] idx);
		logic [15:0] val;
		case (idx)
			4'd0:    val = 16'd1000;
			4'd1:    val = 16'd2000;
			4'd2:    val = 16'd4000;
			4'd3:    val = 16'd8000;
			4'd4:    val = 16'd16000;
			4'd5:    val = 16'd30000;
			default: val = 16'd60000;
		endcase
		return val;
	endfunction

endpackage

### rtl/link_connect_supervisor_backoff.sv
// Top level: link connection supervisor with exponential backoff, timeouts and jitter.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+-------------------------------------------------
//  in      | in_valid / in_stall        | mode, now_ms, link_status, addr_assigned,
//          |                            | begin_failed, jitter_ms, finite_mode
//  out     | out_valid / out_stall      | link_state, attempt_count, error_code,
//          |                            | start_request, drop_request, retry_delay_ms, is_up
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A word is captured in the input register, then the state update and the result are
// computed in one pass and registered in the result register.
// One word is accepted every cycle while the output side keeps up.
// Reset clears the state machine, the attempt counter, the deadlines and both valids,
// and loads the register defaults. A stall on the output holds the result register and
// the input register; the input stalls only when both are full.
`timescale 1ns / 1ps

module link_connect_supervisor_backoff import lcsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] now_ms,
	input  logic [1:0]  link_status,
	input  logic        addr_assigned,
	input  logic        begin_failed,
	input  logic [8:0]  jitter_ms,
	input  logic        finite_mode,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  link_state,
	output logic [7:0]  attempt_count,
	output logic [2:0]  error_code,
	output logic        start_request,
	output logic        drop_request,
	output logic [15:0] retry_delay_ms,
	output logic        is_up,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] timeout_q;
	logic [7:0]  max_att_q;

	logic [2:0]  fsm_q, fsm_n;
	logic [7:0]  att_q, att_n;
	logic [31:0] start_time_q, start_time_n;
	logic [31:0] next_time_q, next_time_n;
	logic        fin_q, fin_n;
	logic [2:0]  err_q, err_n;

	item_t       item_s1;
	logic        valid_s1;
	result_t     res_q, res_n;
	logic        out_valid_q;
	logic        advance;

	logic        do_retry;
	logic [2:0]  retry_reason;
	logic [7:0]  bidx_wide;
	logic [3:0]  bidx;
	logic [8:0]  jit_adj;
	logic [15:0] delay;
	logic [31:0] elapsed;
	logic [31:0] until_next;

	assign cfg_ready = 1'b1;

	// The result register frees up when empty or when its word is taken this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 32'd10000;
			max_att_q <= 8'd2;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TIMEOUT) begin
				timeout_q <= cfg_data;
			end else begin
				max_att_q <= cfg_data[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{mode: mode, now_ms: now_ms, link_status: link_status,
				addr_assigned: addr_assigned, begin_failed: begin_failed,
				jitter_ms: jitter_ms, finite_mode: finite_mode};
		end
	end

	assign elapsed    = item_s1.now_ms - start_time_q;
	assign until_next = item_s1.now_ms - next_time_q;

	always_comb begin
		fsm_n        = fsm_q;
		att_n        = att_q;
		start_time_n = start_time_q;
		next_time_n  = next_time_q;
		fin_n        = fin_q;
		err_n        = err_q;
		do_retry     = 1'b0;
		retry_reason = ERR_NONE;
		res_n        = '0;

		case (item_s1.mode)
			MODE_CONNECT: begin
				fin_n             = item_s1.finite_mode;
				att_n             = 8'd1;
				err_n             = ERR_NONE;
				res_n.drop_request = 1'b1;
				fsm_n             = ST_CONNECTING;
				start_time_n      = item_s1.now_ms;
				res_n.start_request = 1'b1;
				if (item_s1.begin_failed) begin
					do_retry     = 1'b1;
					retry_reason = ERR_REFUSED;
				end
			end
			MODE_STOP: begin
				res_n.drop_request = 1'b1;
				fsm_n             = ST_IDLE;
				att_n             = 8'd0;
			end
			MODE_POLL: begin
				if (fsm_q == ST_CONNECTED) begin
					if (item_s1.link_status != LS_CONNECTED) begin
						do_retry     = 1'b1;
						retry_reason = ERR_LOST;
					end
				end else if (fsm_q == ST_CONNECTING) begin
					if (item_s1.link_status == LS_CONNECTED && item_s1.addr_assigned) begin
						fsm_n = ST_CONNECTED;
						err_n = ERR_NONE;
					end else if (item_s1.link_status inside {LS_FAIL, LS_NO_NET}) begin
						do_retry     = 1'b1;
						retry_reason = ERR_CONNECT;
					end else if (elapsed >= timeout_q) begin
						do_retry     = 1'b1;
						retry_reason = ERR_TIMEOUT;
					end
				end else if (fsm_q == ST_RETRY) begin
					// Deadline reached when the wrapped difference is not negative.
					if (!until_next[31]) begin
						if (att_q != 8'hFF) begin
							att_n = att_q + 8'd1;
						end
						fsm_n               = ST_CONNECTING;
						start_time_n        = item_s1.now_ms;
						res_n.start_request = 1'b1;
						if (item_s1.begin_failed) begin
							do_retry     = 1'b1;
							retry_reason = ERR_REFUSED;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// The backoff step follows the attempt count after any start on this word.
		bidx_wide = (att_n == 8'd0) ? 8'd0 : att_n - 8'd1;
		if (bidx_wide > 8'(BACKOFF_STEPS - 1)) begin
			bidx_wide = 8'(BACKOFF_STEPS - 1);
		end
		bidx    = bidx_wide[3:0];
		jit_adj = (item_s1.jitter_ms > 9'd500) ? item_s1.jitter_ms - JITTER_WRAP
			: item_s1.jitter_ms;
		delay   = backoff_base(bidx) + {7'd0, jit_adj};

		if (do_retry) begin
			err_n              = retry_reason;
			res_n.drop_request = 1'b1;
			if (fin_n && att_n >= max_att_q) begin
				fsm_n = ST_FAILED;
			end else begin
				next_time_n          = item_s1.now_ms + {16'd0, delay};
				fsm_n                = ST_RETRY;
				res_n.retry_delay_ms = delay;
			end
		end

		res_n.link_state    = fsm_n;
		res_n.attempt_count = att_n;
		res_n.error_code    = err_n;
		res_n.is_up         = (fsm_n == ST_CONNECTED) && (item_s1.link_status == LS_CONNECTED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q        <= ST_IDLE;
			att_q        <= 8'd0;
			start_time_q <= 32'd0;
			next_time_q  <= 32'd0;
			fin_q        <= 1'b0;
			err_q        <= ERR_NONE;
		end else if (advance) begin
			fsm_q        <= fsm_n;
			att_q        <= att_n;
			start_time_q <= start_time_n;
			next_time_q  <= next_time_n;
			fin_q        <= fin_n;
			err_q        <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign link_state     = res_q.link_state;
	assign attempt_count  = res_q.attempt_count;
	assign error_code     = res_q.error_code;
	assign start_request  = res_q.start_request;
	assign drop_request   = res_q.drop_request;
	assign retry_delay_ms = res_q.retry_delay_ms;
	assign is_up          = res_q.is_up;

endmodule
